// File: src/srrq_pkg.sv
// Shared types, sizes and codes for the shortest-remaining-time ready queue.
// Depends on nothing; every other file in src refers to it by scoped names.
package srrq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int OCC_W       = 5;
    localparam int ID_W        = 8;
    localparam int TIME_W      = 16;
    localparam int STATUS_W    = 2;

    // request kinds
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_POP    = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_DROPPED   = 2'd2;

    typedef struct packed {
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] remaining_time;
        logic [TIME_W-1:0] arrival_time;
    } t_entry;

    // controller to datapath
    typedef struct packed {
        logic exec;     // apply the request on the ports and load the result register
    } t_cmd;

    // occupancy shows the low OCC_W bits of the count
    function automatic logic [OCC_W-1:0] to_occ(input logic [CNT_W-1:0] count);
        return OCC_W'(count);
    endfunction

endpackage

// File: src/srrq_ctrl.sv
// Handshake controller of the ready queue: tracks whether the result register is full.
// Depends on srrq_pkg for the command struct.
module srrq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    output logic          o_valid,
    input  logic          i_ready,
    output srrq_pkg::t_cmd o_cmd
);

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_HELD  = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    // take a new request when the result slot is free or drains this cycle
    assign o_ready    = (r_state == ST_EMPTY) || i_ready;
    assign accept     = i_valid && o_ready;
    assign o_valid    = (r_state == ST_HELD);
    assign o_cmd.exec = accept;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_EMPTY: begin
                if (accept) n_state = ST_HELD;
            end
            ST_HELD: begin
                if (accept)       n_state = ST_HELD;
                else if (i_ready) n_state = ST_EMPTY;
            end
            default: n_state = ST_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/srrq_dp.sv
// Datapath of the ready queue: sorted shift-register row, entry count, result register.
// Depends on srrq_pkg for sizes, codes and the entry struct.
module srrq_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  srrq_pkg::t_cmd                     i_cmd,
    input  logic                               i_action,
    input  logic [srrq_pkg::ID_W-1:0]          i_job_id,
    input  logic [srrq_pkg::TIME_W-1:0]        i_remaining_time,
    input  logic [srrq_pkg::TIME_W-1:0]        i_arrival_time,
    output logic [srrq_pkg::STATUS_W-1:0]      o_status,
    output logic [srrq_pkg::ID_W-1:0]          o_out_job_id,
    output logic [srrq_pkg::TIME_W-1:0]        o_out_remaining_time,
    output logic [srrq_pkg::TIME_W-1:0]        o_out_arrival_time,
    output logic [srrq_pkg::OCC_W-1:0]         o_occupancy
);

    srrq_pkg::t_entry r_entries [srrq_pkg::QUEUE_DEPTH];
    srrq_pkg::t_entry n_entries [srrq_pkg::QUEUE_DEPTH];
    logic [srrq_pkg::CNT_W-1:0] r_count;
    logic [srrq_pkg::CNT_W-1:0] n_count;

    logic [srrq_pkg::STATUS_W-1:0] r_status, n_status;
    srrq_pkg::t_entry              r_out, n_out;
    logic [srrq_pkg::OCC_W-1:0]    r_occ;

    logic [srrq_pkg::QUEUE_DEPTH-1:0] ahead;
    srrq_pkg::t_entry                 new_entry;
    logic                             is_full;
    logic                             is_empty;

    assign new_entry.job_id         = i_job_id;
    assign new_entry.remaining_time = i_remaining_time;
    assign new_entry.arrival_time   = i_arrival_time;

    assign is_full  = (r_count == srrq_pkg::CNT_W'(srrq_pkg::QUEUE_DEPTH));
    assign is_empty = (r_count == '0);

    // every valid entry compares its key against the new job in parallel;
    // an entry stays ahead on a smaller time, or equal time and no later arrival
    for (genvar k = 0; k < srrq_pkg::QUEUE_DEPTH; k++) begin : g_cmp
        assign ahead[k] = (srrq_pkg::CNT_W'(k) < r_count) &&
            ({r_entries[k].remaining_time, r_entries[k].arrival_time} <=
             {i_remaining_time, i_arrival_time});
    end

    always_comb begin
        n_count  = r_count;
        n_status = srrq_pkg::STAT_DONE;
        n_out    = '0;
        for (int k = 0; k < srrq_pkg::QUEUE_DEPTH; k++) begin
            n_entries[k] = r_entries[k];
        end
        if (i_action == srrq_pkg::ACT_INSERT) begin
            if (is_full) begin
                n_status = srrq_pkg::STAT_DROPPED;
            end else begin
                n_count = r_count + 1'b1;
                // keep the ones ahead, drop the new job into the first gap, shift the rest down
                for (int k = 0; k < srrq_pkg::QUEUE_DEPTH; k++) begin
                    if (ahead[k]) begin
                        n_entries[k] = r_entries[k];
                    end else if (k == 0) begin
                        n_entries[k] = new_entry;
                    end else if (ahead[k-1]) begin
                        n_entries[k] = new_entry;
                    end else begin
                        n_entries[k] = r_entries[k-1];
                    end
                end
            end
        end else begin
            if (is_empty) begin
                n_status = srrq_pkg::STAT_POP_EMPTY;
            end else begin
                n_count = r_count - 1'b1;
                n_out   = r_entries[0];
                for (int k = 0; k < srrq_pkg::QUEUE_DEPTH - 1; k++) begin
                    n_entries[k] = r_entries[k+1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int k = 0; k < srrq_pkg::QUEUE_DEPTH; k++) begin
                r_entries[k] <= n_entries[k];
            end
            r_status <= n_status;
            r_out    <= n_out;
            r_occ    <= srrq_pkg::to_occ(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    assign o_status             = r_status;
    assign o_out_job_id         = r_out.job_id;
    assign o_out_remaining_time = r_out.remaining_time;
    assign o_out_arrival_time   = r_out.arrival_time;
    assign o_occupancy          = r_occ;

endmodule

// File: src/shortest_remaining_ready_queue.sv
// Top level of the shortest-remaining-time-first ready queue.
// Depends on srrq_pkg, srrq_ctrl and srrq_dp.
//
//  channel   | handshake          | payload
//  ----------+--------------------+-----------------------------------------------------
//  request   | i_valid / o_ready  | i_action, i_job_id, i_remaining_time, i_arrival_time
//  result    | o_valid / i_ready  | o_status, o_out_job_id, o_out_remaining_time,
//            |                    | o_out_arrival_time, o_occupancy
//
// Cycles: one request per cycle while i_ready takes each result; its result shows in the
//   result register on the next cycle. The figure is set by the row of parallel key
//   compares across all queue entries, which places an insert or shifts out the head combinationally.
// Reset: synchronous, active low; clears the entry count and marks the result slot empty.
//   Entry contents are left as they are, since only entries below the count are ever read.
// Stalls: while a result waits and i_ready is low, o_ready drops and no request is taken;
//   a result taken in the same cycle frees the slot for the next request at once.
module shortest_remaining_ready_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_action,
    input  logic [srrq_pkg::ID_W-1:0]          i_job_id,
    input  logic [srrq_pkg::TIME_W-1:0]        i_remaining_time,
    input  logic [srrq_pkg::TIME_W-1:0]        i_arrival_time,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [srrq_pkg::STATUS_W-1:0]      o_status,
    output logic [srrq_pkg::ID_W-1:0]          o_out_job_id,
    output logic [srrq_pkg::TIME_W-1:0]        o_out_remaining_time,
    output logic [srrq_pkg::TIME_W-1:0]        o_out_arrival_time,
    output logic [srrq_pkg::OCC_W-1:0]         o_occupancy
);

    srrq_pkg::t_cmd cmd;

    // handshake and result-slot tracking
    srrq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    // sorted queue row and result register
    srrq_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .i_action             (i_action),
        .i_job_id             (i_job_id),
        .i_remaining_time     (i_remaining_time),
        .i_arrival_time       (i_arrival_time),
        .o_status             (o_status),
        .o_out_job_id         (o_out_job_id),
        .o_out_remaining_time (o_out_remaining_time),
        .o_out_arrival_time   (o_out_arrival_time),
        .o_occupancy          (o_occupancy)
    );

    // an accepted request always leaves a result in the slot on the next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> o_valid)
        else $error("accepted request produced no result");

    // a dropped insert only happens with the queue at full depth
    a_drop_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == srrq_pkg::STAT_DROPPED)) |->
        (o_occupancy == srrq_pkg::to_occ(srrq_pkg::CNT_W'(srrq_pkg::QUEUE_DEPTH))))
        else $error("insert dropped while queue not full");

    // a pop on an empty queue reports an empty queue and no job
    a_empty_pop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status == srrq_pkg::STAT_POP_EMPTY)) |->
        ((o_occupancy == '0) && (o_out_job_id == '0) &&
         (o_out_remaining_time == '0) && (o_out_arrival_time == '0)))
        else $error("empty pop result inconsistent");

endmodule
